[design/basic_waveform_oscillator_core_defines.svh]
// Assertion macros used by the checker file of the oscillator.
`ifndef BASIC_WAVEFORM_OSCILLATOR_CORE_DEFINES_SVH
`define BASIC_WAVEFORM_OSCILLATOR_CORE_DEFINES_SVH

// Property checked on every rising edge of clk, ignored while reset is held.
`define BWO_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every rising edge of clk, reset included.
`define BWO_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/bwo_pkg.sv]
`timescale 1ns / 1ps

package bwo_pkg;

    // Fixed field widths of the streams.
    localparam int SAMPLE_W    = 16;
    localparam int NUMBER_W    = 24;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 40;
    localparam int APB_ADDR_W  = 4;
    localparam int APB_DATA_W  = 32;
    localparam int ROM_W       = 17;

    // Configuration register map, by word index.
    typedef enum logic [1:0] {
        REG_WAVEFORM  = 2'd0,
        REG_STEP      = 2'd1,
        REG_AMPLITUDE = 2'd2,
        REG_LENGTH    = 2'd3
    } cfg_reg_t;

    // Waveform selection codes.
    typedef enum logic [1:0] {
        WAVE_SINE     = 2'd0,
        WAVE_SQUARE   = 2'd1,
        WAVE_SAW      = 2'd2,
        WAVE_TRIANGLE = 2'd3
    } wave_t;

    // Register values after reset.
    localparam logic [31:0] STEP_RESET      = 32'd39370534;
    localparam logic [14:0] AMPLITUDE_RESET = 15'd16384;
    localparam logic [23:0] LENGTH_RESET    = 24'd48000;

    // Unity in Q1.15, which is one step beyond the positive range.
    localparam logic [16:0] ONE_Q15 = 17'd32768;

    // Taylor coefficients of sin(pi/2 * x) in Q30, odd powers 1 to 11.
    localparam logic [63:0] POLY_Q30 [6] = '{
        64'd1686629713, 64'd693598668, 64'd85569306,
        64'd5026995, 64'd172272, 64'd3864
    };

    // Everything the second stage needs of one item, besides the table word.
    typedef struct packed {
        logic                neg_sine;
        logic                sq_zero;
        logic                sq_neg;
        logic [15:0]         p16;
        logic [NUMBER_W-1:0] number;
        logic                last;
    } s1_t;

    // Quarter-wave sine entry i of a table with 2^tbits steps, value 0..32768.
    // Evaluated only at elaboration to fill the table.
    function automatic logic [ROM_W-1:0] quarter_sine(input int unsigned i,
                                                      input int unsigned tbits);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] acc;
        logic [63:0] v;
        x   = 64'(i) << (30 - tbits);
        x2  = (x * x) >> 30;
        acc = POLY_Q30[5];
        for (int k = 4; k >= 0; k--)
        begin
            acc = POLY_Q30[k] - ((acc * x2) >> 30);
        end
        v = ((((acc * x) >> 30) * 64'd32768) + (64'd1 << 29)) >> 30;
        if (v > 64'd32768)
        begin
            v = 64'd32768;
        end
        return v[ROM_W-1:0];
    endfunction

endpackage

[design/bwo_sine_rom.sv]
`timescale 1ns / 1ps

module bwo_sine_rom #(
    parameter int TABLE_BITS = 10
) (
    input  logic                      clk,
    input  logic                      en,
    input  logic [TABLE_BITS:0]       addr,
    output logic [bwo_pkg::ROM_W-1:0] data
);

    localparam int DEPTH = (1 << TABLE_BITS) + 1;

    logic [bwo_pkg::ROM_W-1:0] rom_table [DEPTH];
    logic [bwo_pkg::ROM_W-1:0] data_reg;

    // Constant quarter-wave contents, both ends included.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_fill
        assign rom_table[i] = bwo_pkg::quarter_sine(i, TABLE_BITS);
    end

    // Registered read.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= rom_table[addr];
        end
    end

    assign data = data_reg;

endmodule

[design/basic_waveform_oscillator_core.sv]
`timescale 1ns / 1ps
// Waveform oscillator (phase accumulator with sine, square, saw and triangle).
// Each item on the input stream is one sample tick; s_tdata bit 0 is restart,
// which clears the phase and the sample counter before that sample is made.
// Each accepted item yields one output item: m_tdata carries the signed sample
// and its index within the tone, and m_tlast marks the last sample of a tone.
// Waveform, phase step, amplitude and tone length are set over the APB port,
// which is always ready; registers may be changed only while the stream is idle.
// From input accept to output valid an item passes the first stage (registered
// sine table read) and the output register (waveform select and amplitude
// multiply). Throughput is one item per clock while the output is taken; phase
// and counter update on accept. If the receiver stalls, the output register
// holds its item and an empty first stage takes one more; once it is full, s_tready
// drops until the output is taken. Reset clears phase, counter and both stage
// valid flags and restores the register defaults; no clearing pass is needed.
module basic_waveform_oscillator_core #(
    parameter int PHASE_BITS      = 32,
    parameter int SINE_TABLE_BITS = 10,
    parameter int COUNT_BITS      = 24
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // Input stream; s_tdata: [0] restart, [7:1] zero.
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [bwo_pkg::IN_TDATA_W-1:0]   s_tdata,
    // Output stream; m_tdata: [15:0] sample, [39:16] sample_number.
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [bwo_pkg::OUT_TDATA_W-1:0]  m_tdata,
    output logic                             m_tlast,
    // Configuration port.
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [bwo_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [bwo_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [bwo_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);

    localparam int TB      = SINE_TABLE_BITS;
    localparam int STEP_W  = (PHASE_BITS > 32) ? PHASE_BITS : 32;
    localparam int NUM_W   = (COUNT_BITS > bwo_pkg::NUMBER_W) ? COUNT_BITS
                                                               : bwo_pkg::NUMBER_W;
    localparam int CMP_W   = (COUNT_BITS + 1 > bwo_pkg::NUMBER_W) ? COUNT_BITS + 1
                                                                   : bwo_pkg::NUMBER_W;
    localparam logic [TB:0] QUARTER = (TB + 1)'(1) << TB;
    localparam logic signed [16:0] W_POS = 17'sd32768;
    localparam logic signed [16:0] W_NEG = -17'sd32768;

    // Configuration registers.
    bwo_pkg::wave_t  waveform_select_reg;
    logic [31:0]     phase_step_reg;
    logic [14:0]     amplitude_reg;
    logic [23:0]     tone_length_reg;

    // Oscillator state.
    logic [PHASE_BITS-1:0] phase_reg;
    logic [PHASE_BITS-1:0] phase_next;
    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;

    // Pipeline registers.
    logic                s1_valid_reg;
    bwo_pkg::s1_t        s1_reg;
    bwo_pkg::s1_t        s1_next;
    logic                out_valid_reg;
    logic [15:0]         out_sample_reg;
    logic [15:0]         out_sample_next;
    logic [23:0]         out_number_reg;
    logic                out_last_reg;

    logic                  cfg_write;
    bwo_pkg::cfg_reg_t     cfg_sel;
    logic                  out_ready;
    logic                  accept;
    logic [PHASE_BITS-1:0] phase_eff;
    logic [COUNT_BITS-1:0] count_eff;
    logic [STEP_W-1:0]     step_wide;
    logic [NUM_W-1:0]      number_wide;
    logic [CMP_W-1:0]      count_plus;
    logic                  last;
    logic [1:0]            quad;
    logic [TB-1:0]         idx;
    logic [TB:0]           rom_addr;
    logic [16:0]           rom_data;
    logic [16:0]           tri_mag;
    logic signed [17:0]    tri_w;
    logic signed [16:0]    wave;
    logic signed [32:0]    prod;

    // Configuration writes and reads.
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_sel   = bwo_pkg::cfg_reg_t'(paddr[3:2]);
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            waveform_select_reg <= bwo_pkg::WAVE_SINE;
            phase_step_reg      <= bwo_pkg::STEP_RESET;
            amplitude_reg       <= bwo_pkg::AMPLITUDE_RESET;
            tone_length_reg     <= bwo_pkg::LENGTH_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_sel)
                bwo_pkg::REG_WAVEFORM:  waveform_select_reg <= bwo_pkg::wave_t'(pwdata[1:0]);
                bwo_pkg::REG_STEP:      phase_step_reg      <= pwdata;
                bwo_pkg::REG_AMPLITUDE: amplitude_reg       <= pwdata[14:0];
                bwo_pkg::REG_LENGTH:    tone_length_reg     <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_sel)
            bwo_pkg::REG_WAVEFORM:  prdata = 32'(waveform_select_reg);
            bwo_pkg::REG_STEP:      prdata = phase_step_reg;
            bwo_pkg::REG_AMPLITUDE: prdata = 32'(amplitude_reg);
            bwo_pkg::REG_LENGTH:    prdata = 32'(tone_length_reg);
            default:                prdata = '0;
        endcase
    end

    // Handshake: the first stage moves on whenever the output register frees up.
    assign out_ready = !out_valid_reg || m_tready;
    assign s_tready  = !s1_valid_reg || out_ready;
    assign accept    = s_tvalid && s_tready;

    // Phase and counter seen by this sample, after an optional restart.
    assign phase_eff = s_tdata[0] ? '0 : phase_reg;
    assign count_eff = s_tdata[0] ? '0 : count_reg;

    assign step_wide  = STEP_W'(phase_step_reg);
    assign phase_next = phase_eff + step_wide[PHASE_BITS-1:0];

    // Tone end: last when count + 1 reaches the length (also for length zero).
    assign count_plus = CMP_W'(count_eff) + CMP_W'(1);
    assign last       = count_plus >= CMP_W'(tone_length_reg);
    assign count_next = last ? '0 : count_plus[COUNT_BITS-1:0];
    assign number_wide = NUM_W'(count_eff);

    // Sine table address, mirrored in the odd quadrants.
    assign quad     = phase_eff[PHASE_BITS-1 -: 2];
    assign idx      = phase_eff[PHASE_BITS-3 -: TB];
    assign rom_addr = quad[0] ? (QUARTER - {1'b0, idx}) : {1'b0, idx};

    always_comb
    begin
        s1_next.neg_sine = quad[1];
        s1_next.sq_zero  = (phase_eff[PHASE_BITS-2:0] == '0);
        s1_next.sq_neg   = phase_eff[PHASE_BITS-1];
        s1_next.p16      = phase_eff[PHASE_BITS-1 -: 16];
        s1_next.number   = number_wide[bwo_pkg::NUMBER_W-1:0];
        s1_next.last     = last;
    end

    bwo_sine_rom #(
        .TABLE_BITS (TB)
    ) u_sine_rom (
        .clk  (clk),
        .en   (accept),
        .addr (rom_addr),
        .data (rom_data)
    );

    // Oscillator state advances once per accepted item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
            count_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
        end
    end

    // First stage register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= s1_next;
        end
    end

    // Triangle: 2*|p16 - 32768| - 32768.
    assign tri_mag = s1_reg.p16[15] ? {2'b00, s1_reg.p16[14:0]}
                                    : (bwo_pkg::ONE_Q15 - {1'b0, s1_reg.p16});
    assign tri_w   = $signed({tri_mag, 1'b0}) - 18'sd32768;

    // Waveform value in Q1.15.
    always_comb
    begin
        unique case (waveform_select_reg)
            bwo_pkg::WAVE_SINE:
            begin
                wave = s1_reg.neg_sine ? -$signed(rom_data) : $signed(rom_data);
            end
            bwo_pkg::WAVE_SQUARE:
            begin
                if (s1_reg.sq_zero)
                begin
                    wave = '0;
                end
                else
                begin
                    wave = s1_reg.sq_neg ? W_NEG : W_POS;
                end
            end
            bwo_pkg::WAVE_SAW:      wave = $signed({1'b0, s1_reg.p16}) - W_POS;
            bwo_pkg::WAVE_TRIANGLE: wave = tri_w[16:0];
            default:                wave = '0;
        endcase
    end

    // Scale by amplitude; the arithmetic shift rounds toward minus infinity.
    assign prod            = $signed({1'b0, amplitude_reg}) * wave;
    assign out_sample_next = prod[30:15];

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready && s1_valid_reg)
        begin
            out_sample_reg <= out_sample_next;
            out_number_reg <= s1_reg.number;
            out_last_reg   <= s1_reg.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_number_reg, out_sample_reg};
    assign m_tlast  = out_last_reg;

endmodule

[design/bwo_checker.sv]
`timescale 1ns / 1ps
`include "basic_waveform_oscillator_core_defines.svh"

module bwo_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic [bwo_pkg::IN_TDATA_W-1:0]   s_tdata,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [bwo_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input logic                             m_tlast
);

    // A stalled output item holds its value.
    `BWO_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast), "output item changed while stalled")

    // With the output register empty, the input side must be open.
    `BWO_ASSERT(a_ready_when_empty, !m_tvalid |-> s_tready, "input blocked while output empty")

    // An accepted item reaches the output after the first stage and the output register.
    `BWO_ASSERT(a_latency, s_tvalid && s_tready |=> ##1 m_tvalid, "accepted item did not reach output")

    // Nothing is offered once reset has been seen at a clock edge.
    `BWO_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !m_tvalid, "output valid during reset")

endmodule

bind basic_waveform_oscillator_core bwo_checker u_bwo_checker (.*);
